### hw/rtl/fmu_pkg.sv
package fmu_pkg;

  // Membership degree format: unsigned Q1.15, full scale 1.0 = 0x8000.
  localparam int DEG_W  = 16;
  localparam int QBITS  = 15;
  localparam logic [DEG_W-1:0] DEG_ONE  = 16'h8000;
  localparam logic [DEG_W-1:0] DEG_ZERO = 16'h0000;

  // Configuration register map
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SHAPE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BREAK_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BREAK_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BREAK_C = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BREAK_D = 3'd4;

  // Shape codes
  localparam int SHAPE_W = 2;
  typedef enum logic [SHAPE_W-1:0] {
    SHAPE_LEFT      = 2'd0,
    SHAPE_RIGHT     = 2'd1,
    SHAPE_TRIANGLE  = 2'd2,
    SHAPE_TRAPEZOID = 2'd3
  } shape_t;

  localparam int DEF_DATA_WIDTH = 16;
  localparam int RST_BREAK_A = 0;
  localparam int RST_BREAK_B = 256;
  localparam int RST_BREAK_C = 512;
  localparam int RST_BREAK_D = 768;

  // Per-transaction control that rides alongside the divider data
  typedef struct packed {
    logic valid;
    logic is_const;   // degree is a flat 0 or 1.0, divider result ignored
    logic const_one;  // flat value is 1.0
  } fmu_ctl_t;

endpackage

### hw/rtl/fuzzy_membership_unit.sv
// Channel   Ports                                  Handshake
// ------    -------------------------------------  ---------------------------------
// input     start, busy, in_sample                 taken when start && !busy
// result    out_valid, out_degree                  one-cycle strobe, no back-pressure
// config    cfg_valid, cfg_ready, cfg_index,       written when cfg_valid && cfg_ready
//           cfg_data
//
// Throughput is one sample per clock once out of reset. The pipeline is one
// classify/subtract stage, one divider cell per quotient bit (15) and one
// output register.
// Reset is synchronous, active low; busy and cfg_ready stay high/low through
// reset and are released by a register in the cycle after it. The result
// side cannot stall, so busy is never raised in normal operation.
module fuzzy_membership_unit import fmu_pkg::*; #(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input transaction
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] in_sample,
  // result transaction
  output logic                         out_valid,
  output logic        [DEG_W-1:0]      out_degree,
  // configuration writes
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic        [CFG_IDX_W-1:0]  cfg_index,
  input  logic        [DATA_WIDTH-1:0] cfg_data
);

  localparam int LAT = QBITS + 2;

  // Held in reset -> not ready for anything
  logic ready_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r <= 1'b0;
    end else begin
      ready_r <= 1'b1;
    end
  end

  assign busy      = !ready_r;
  assign cfg_ready = ready_r;

  // Configuration registers
  shape_t                       shape_r;
  logic signed [DATA_WIDTH-1:0] brk_a_r, brk_b_r, brk_c_r, brk_d_r;
  logic                         cfg_wr;

  assign cfg_wr = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_r <= SHAPE_TRAPEZOID;
      brk_a_r <= DATA_WIDTH'(RST_BREAK_A);
      brk_b_r <= DATA_WIDTH'(RST_BREAK_B);
      brk_c_r <= DATA_WIDTH'(RST_BREAK_C);
      brk_d_r <= DATA_WIDTH'(RST_BREAK_D);
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_SHAPE:   shape_r <= shape_t'(cfg_data[SHAPE_W-1:0]);
        REG_BREAK_A: brk_a_r <= cfg_data;
        REG_BREAK_B: brk_b_r <= cfg_data;
        REG_BREAK_C: brk_c_r <= cfg_data;
        REG_BREAK_D: brk_d_r <= cfg_data;
        default: ;  // unmapped index: dropped
      endcase
    end
  end

  // Classify the sample, pick ramp numerator/denominator
  fmu_ctl_t              ctl_s [QBITS+1];
  logic [DATA_WIDTH-1:0] rem_s [QBITS+1];
  logic [DATA_WIDTH-1:0] den_s [QBITS+1];
  logic [QBITS-1:0]      quo_s [QBITS+1];

  fmu_front #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start && !busy),
    .shape    (shape_r),
    .brk_a    (brk_a_r),
    .brk_b    (brk_b_r),
    .brk_c    (brk_c_r),
    .brk_d    (brk_d_r),
    .sample   (in_sample),
    .ctl_o    (ctl_s[0]),
    .num_o    (rem_s[0]),
    .den_o    (den_s[0])
  );

  assign quo_s[0] = '0;

  // Divider chain: each cell resolves one quotient bit of num*2^15/den, MSB first
  for (genvar i = 0; i < QBITS; i++) begin : g_cell
    fmu_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (ctl_s[i]),
      .rem_i (rem_s[i]),
      .den_i (den_s[i]),
      .quo_i (quo_s[i]),
      .ctl_o (ctl_s[i+1]),
      .rem_o (rem_s[i+1]),
      .den_o (den_s[i+1]),
      .quo_o (quo_s[i+1])
    );
  end

  // Output register: flat value or the ramp quotient
  fmu_ctl_t         ctl_last;
  logic             out_valid_r;
  logic [DEG_W-1:0] out_degree_r, degree_nxt;

  assign ctl_last = ctl_s[QBITS];

  always_comb begin
    if (ctl_last.is_const) begin
      degree_nxt = ctl_last.const_one ? DEG_ONE : DEG_ZERO;
    end else begin
      degree_nxt = {{(DEG_W-QBITS){1'b0}}, quo_s[QBITS]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl_last.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_degree_r <= degree_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_degree = out_degree_r;

`ifndef SYNTHESIS
  // Every accepted sample shows up as a result once through the pipeline
  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("accepted sample produced no result");

  // No result without a matching accepted sample
  a_lat_bwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without accepted sample");

  // Degree never exceeds 1.0
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_degree <= DEG_ONE))
    else $error("degree above full scale");
`endif

endmodule

### hw/rtl/fmu_front.sv
module fmu_front import fmu_pkg::*; #(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  shape_t                       shape,
  input  logic signed [DATA_WIDTH-1:0] brk_a,
  input  logic signed [DATA_WIDTH-1:0] brk_b,
  input  logic signed [DATA_WIDTH-1:0] brk_c,
  input  logic signed [DATA_WIDTH-1:0] brk_d,
  input  logic signed [DATA_WIDTH-1:0] sample,
  output fmu_ctl_t                     ctl_o,
  output logic        [DATA_WIDTH-1:0] num_o,
  output logic        [DATA_WIDTH-1:0] den_o
);

  logic signed [DATA_WIDTH:0] x_e, a_e, b_e, c_e, d_e;
  logic signed [DATA_WIDTH:0] xa, bx, ba, cx, cb, dx, dc;
  logic signed [DATA_WIDTH:0] num_sel, den_sel;
  logic                       is_const, const_one;

  fmu_ctl_t              ctl_r, ctl_nxt;
  logic [DATA_WIDTH-1:0] num_r, den_r;

  assign x_e = $signed({sample[DATA_WIDTH-1], sample});
  assign a_e = $signed({brk_a[DATA_WIDTH-1], brk_a});
  assign b_e = $signed({brk_b[DATA_WIDTH-1], brk_b});
  assign c_e = $signed({brk_c[DATA_WIDTH-1], brk_c});
  assign d_e = $signed({brk_d[DATA_WIDTH-1], brk_d});

  assign xa = x_e - a_e;
  assign bx = b_e - x_e;
  assign ba = b_e - a_e;
  assign cx = c_e - x_e;
  assign cb = c_e - b_e;
  assign dx = d_e - x_e;
  assign dc = d_e - c_e;

  // Rule selection; on any ramp the sample lies strictly inside the span,
  // so 0 < num < den < 2**DATA_WIDTH.
  always_comb begin
    is_const  = 1'b0;
    const_one = 1'b0;
    num_sel   = xa;
    den_sel   = ba;
    case (shape)
      SHAPE_LEFT: begin
        if (sample <= brk_a) begin
          is_const  = 1'b1;
          const_one = 1'b1;
        end else if (sample >= brk_b) begin
          is_const = 1'b1;
        end else begin
          num_sel = bx;
        end
      end
      SHAPE_RIGHT: begin
        if (sample <= brk_a) begin
          is_const = 1'b1;
        end else if (sample >= brk_b) begin
          is_const  = 1'b1;
          const_one = 1'b1;
        end
      end
      SHAPE_TRIANGLE: begin
        if (sample <= brk_a || sample >= brk_c) begin
          is_const = 1'b1;
        end else if (sample == brk_b) begin
          is_const  = 1'b1;
          const_one = 1'b1;
        end else if (sample > brk_b) begin
          num_sel = cx;
          den_sel = cb;
        end
      end
      default: begin
        if (sample <= brk_a || sample >= brk_d) begin
          is_const = 1'b1;
        end else if (sample >= brk_b && sample <= brk_c) begin
          is_const  = 1'b1;
          const_one = 1'b1;
        end else if (sample >= brk_b) begin
          num_sel = dx;
          den_sel = dc;
        end
      end
    endcase
  end

  always_comb begin
    ctl_nxt.valid     = in_valid;
    ctl_nxt.is_const  = is_const;
    ctl_nxt.const_one = const_one;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_sel[DATA_WIDTH-1:0];
    den_r <= den_sel[DATA_WIDTH-1:0];
  end

  assign ctl_o = ctl_r;
  assign num_o = num_r;
  assign den_o = den_r;

endmodule

### hw/rtl/fmu_cell.sv
module fmu_cell import fmu_pkg::*; #(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fmu_ctl_t              ctl_i,
  input  logic [DATA_WIDTH-1:0] rem_i,
  input  logic [DATA_WIDTH-1:0] den_i,
  input  logic [QBITS-1:0]      quo_i,
  output fmu_ctl_t              ctl_o,
  output logic [DATA_WIDTH-1:0] rem_o,
  output logic [DATA_WIDTH-1:0] den_o,
  output logic [QBITS-1:0]      quo_o
);

  // One restoring-division step: rem < den holds on entry and exit.
  logic [DATA_WIDTH:0]   rem2, diff;
  logic                  ge;
  fmu_ctl_t              ctl_r;
  logic [DATA_WIDTH-1:0] rem_r, rem_nxt, den_r;
  logic [QBITS-1:0]      quo_r, quo_nxt;

  assign rem2    = {rem_i, 1'b0};
  assign ge      = rem2 >= {1'b0, den_i};
  assign diff    = rem2 - {1'b0, den_i};
  assign rem_nxt = ge ? diff[DATA_WIDTH-1:0] : rem2[DATA_WIDTH-1:0];
  assign quo_nxt = {quo_i[QBITS-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_i;
    quo_r <= quo_nxt;
  end

  assign ctl_o = ctl_r;
  assign rem_o = rem_r;
  assign den_o = den_r;
  assign quo_o = quo_r;

endmodule

### sim/tb.sv
`timescale 1ns / 100ps

module tb import fmu_pkg::*; ();

  // Block sizing and run limits
  localparam int DW            = DEF_DATA_WIDTH;
  localparam int LATENCY       = QBITS + 2;   // classify + divider cells + output reg
  localparam int CYCLE_LIMIT   = 400000;      // far above the slowest legal run
  localparam int RANDOM_PHASES = 30;          // one random shape setting per phase
  localparam int CALM_PHASES   = 4;           // trailing phases send their samples back to back
  localparam int MAX_PRINTS    = 50;

  typedef logic signed [DW-1:0] sample_t;

  localparam sample_t SAMPLE_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam sample_t SAMPLE_MAX = {1'b0, {(DW-1){1'b1}}};

  // One accepted sample and the degree it must produce
  typedef struct {
    sample_t          sample;
    logic [DEG_W-1:0] degree;
  } degree_txn_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  sample_t              in_sample;
  logic                 out_valid;
  logic [DEG_W-1:0]     out_degree;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DW-1:0]        cfg_data;

  // Local copy of the block's registers, updated on each accepted write
  shape_t  shape_cfg;
  sample_t bp [4];

  degree_txn_t pending_degrees [$];

  int error_count;
  int items_sent;
  int results_seen;
  int phases_run;
  int cycle_count;

  fuzzy_membership_unit #(
    .DATA_WIDTH(DW)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_sample  (in_sample),
    .out_valid  (out_valid),
    .out_degree (out_degree),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_degrees.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    if (error_count < MAX_PRINTS)
      $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Degree predictor
  // ---------------------------------------------------------------------------

  // num * 1.0 / den in Q1.15, truncated; a ramp is only reached with 0 < num < den
  function automatic logic [DEG_W-1:0] ramp_q15(longint num, longint den);
    longint q;
    if (den <= 0 || num <= 0)
      return DEG_ZERO;
    if (num >= den)
      return DEG_ONE;
    q = (num << QBITS) / den;
    return q[DEG_W-1:0];
  endfunction

  // Rules are tested in a fixed order, so unordered breakpoints still give one answer
  function automatic logic [DEG_W-1:0] membership_of(sample_t x);
    longint sx, a, b, c, d;
    sx = x;
    a  = bp[0];
    b  = bp[1];
    c  = bp[2];
    d  = bp[3];
    case (shape_cfg)
      SHAPE_LEFT: begin
        if (sx <= a)      return DEG_ONE;
        else if (sx >= b) return DEG_ZERO;
        else              return ramp_q15(b - sx, b - a);
      end
      SHAPE_RIGHT: begin
        if (sx <= a)      return DEG_ZERO;
        else if (sx >= b) return DEG_ONE;
        else              return ramp_q15(sx - a, b - a);
      end
      SHAPE_TRIANGLE: begin
        if (sx <= a || sx >= c) return DEG_ZERO;
        else if (sx == b)       return DEG_ONE;
        else if (sx < b)        return ramp_q15(sx - a, b - a);
        else                    return ramp_q15(c - sx, c - b);
      end
      default: begin
        if (sx <= a || sx >= d)     return DEG_ZERO;
        else if (sx >= b && sx <= c) return DEG_ONE;
        else if (sx < b)            return ramp_q15(sx - a, b - a);
        else                        return ramp_q15(d - sx, d - c);
      end
    endcase
  endfunction

  // Mirror of the register file; unmapped indexes leave everything alone
  function automatic void apply_write(logic [CFG_IDX_W-1:0] idx, logic [DW-1:0] data);
    case (idx)
      REG_SHAPE:   shape_cfg = shape_t'(data[SHAPE_W-1:0]);
      REG_BREAK_A: bp[0] = data;
      REG_BREAK_B: bp[1] = data;
      REG_BREAK_C: bp[2] = data;
      REG_BREAK_D: bp[3] = data;
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every strobe is matched against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    degree_txn_t want;
    if (rst_n) begin
      if ($isunknown(out_valid)) begin
        report_mismatch("out_valid is unknown");
      end else if (out_valid) begin
        results_seen++;
        if (pending_degrees.size() == 0) begin
          report_mismatch($sformatf("unexpected result, degree 0x%04h", out_degree));
        end else begin
          want = pending_degrees.pop_front();
          if (out_degree !== want.degree)
            report_mismatch($sformatf("sample %0d: degree 0x%04h, expected 0x%04h",
                                      want.sample, out_degree, want.degree));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers: inputs move on the falling edge, handshakes are seen on the rising edge
  // ---------------------------------------------------------------------------

  // One input transaction; start is left high so a following item goes back to back
  task automatic send_sample(sample_t x);
    @(negedge clk);
    start     <= 1'b1;
    in_sample <= x;
    do @(posedge clk); while (busy !== 1'b0);
    pending_degrees.push_back('{x, membership_of(x)});
    items_sent++;
  endtask

  // Sender gap; the sample bus carries junk while start is low
  task automatic idle_input(int n);
    repeat (n) begin
      @(negedge clk);
      start     <= 1'b0;
      in_sample <= sample_t'($urandom);
    end
  endtask

  // Hold off input until every outstanding result has come back
  task automatic drain_results();
    idle_input(1);
    while (pending_degrees.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    apply_write(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_index <= CFG_IDX_W'($urandom);
    cfg_data  <= DW'($urandom);
  endtask

  // Full register set; junk in the shape word's upper bits must be dropped
  task automatic set_shape(shape_t s, sample_t a, sample_t b, sample_t c, sample_t d);
    logic [DW-1:0] shape_word;
    shape_word                = DW'($urandom);
    shape_word[SHAPE_W-1:0]   = s;
    write_reg(REG_SHAPE, shape_word);
    write_reg(REG_BREAK_A, a);
    write_reg(REG_BREAK_B, b);
    write_reg(REG_BREAK_C, c);
    write_reg(REG_BREAK_D, d);
  endtask

  // ---------------------------------------------------------------------------
  // Random choices
  // ---------------------------------------------------------------------------

  // Mostly ascending breakpoints at varied spans; some pinned to the rails,
  // some with coinciding points, some in no order at all
  task automatic pick_random_shape();
    sample_t pts [$];
    sample_t base;
    int      mode;
    int      span;
    shape_t  s;
    s    = shape_t'($urandom_range(0, 3));
    mode = $urandom_range(0, 99);
    case ($urandom_range(0, 2))
      0:       span = 64;
      1:       span = 2048;
      default: span = 65535;
    endcase
    base = sample_t'($urandom);
    for (int i = 0; i < 4; i++)
      pts.push_back(base + sample_t'($urandom_range(0, span)));
    if (mode < 85)
      pts.sort();
    if (mode >= 60 && mode < 75) begin
      pts[0] = SAMPLE_MIN;
      pts[3] = SAMPLE_MAX;
    end else if (mode >= 75 && mode < 85) begin
      if ($urandom_range(0, 1)) pts[1] = pts[0];
      else                      pts[2] = pts[1];
    end else if (mode >= 85) begin
      foreach (pts[i]) pts[i] = sample_t'($urandom);
    end
    set_shape(s, pts[0], pts[1], pts[2], pts[3]);
  endtask

  // Samples cluster on the breakpoints and slopes where the rounding lives
  function automatic sample_t pick_sample();
    int     r;
    int     w;
    longint lo, hi, tmp;
    r = $urandom_range(0, 99);
    w = ($urandom_range(0, 1)) ? 4 : 256;
    lo = bp[0];
    hi = bp[3];
    if (r < 45)
      return bp[$urandom_range(0, 3)] + sample_t'(int'($urandom_range(0, 2 * w)) - w);
    if (r < 75) begin
      if (hi < lo) begin
        tmp = lo;
        lo  = hi;
        hi  = tmp;
      end
      return sample_t'(lo + longint'($urandom_range(0, int'(hi - lo))));
    end
    if (r < 88)
      return sample_t'($urandom);
    case ($urandom_range(0, 2))
      0:       return SAMPLE_MIN;
      1:       return SAMPLE_MAX;
      default: return bp[$urandom_range(0, 3)];
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Power-up shape is the trapezoid with breakpoints 0 / 256 / 512 / 768
  task automatic test_reset_shape();
    send_sample(SAMPLE_MIN);
    send_sample(1);
    send_sample(256);
    send_sample(512);
    send_sample(767);
    send_sample(SAMPLE_MAX);
  endtask

  // Unused breakpoints parked at odd values to prove they are ignored
  task automatic test_left_shoulder();
    drain_results();
    set_shape(SHAPE_LEFT, -256, 256, SAMPLE_MIN, SAMPLE_MIN);
    send_sample(-256);
    send_sample(0);
    send_sample(255);
    send_sample(256);
  endtask

  // Widest possible ramp: span of the whole sample range
  task automatic test_right_shoulder();
    drain_results();
    set_shape(SHAPE_RIGHT, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN);
    send_sample(SAMPLE_MIN + 1);
    send_sample(0);
    send_sample(SAMPLE_MAX - 1);
    send_sample(SAMPLE_MAX);
  endtask

  task automatic test_triangle();
    drain_results();
    set_shape(SHAPE_TRIANGLE, -100, 0, 100, SAMPLE_MIN);
    send_sample(-99);
    send_sample(0);
    send_sample(50);
    send_sample(100);
  endtask

  // Breakpoints out of order: rule order alone decides
  task automatic test_unordered_breaks();
    drain_results();
    set_shape(SHAPE_TRAPEZOID, -512, 512, -256, 256);
    send_sample(0);
    send_sample(200);
    send_sample(-600);
  endtask

  // Writes above the register map must not disturb the shape
  task automatic test_unused_index();
    drain_results();
    for (int idx = REG_BREAK_D + 1; idx < (1 << CFG_IDX_W); idx++)
      write_reg(CFG_IDX_W'(idx), DW'($urandom));
    send_sample(-300);
  endtask

  task automatic test_random_traffic();
    int n;
    bit calm;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      calm = (p >= RANDOM_PHASES - CALM_PHASES);
      drain_results();
      pick_random_shape();
      phases_run++;
      n = $urandom_range(20, 40);
      for (int i = 0; i < n; i++) begin
        if (!calm && $urandom_range(0, 3) == 0)
          idle_input($urandom_range(1, 17));
        // let the pipe run empty mid-phase at least once
        if (!calm && ((p == RANDOM_PHASES / 2 && i == n / 2) || $urandom_range(0, 99) == 0))
          drain_results();
        send_sample(pick_sample());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n      = 1'b0;
    start      = 1'b0;
    in_sample  = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    shape_cfg  = SHAPE_TRAPEZOID;
    bp[0]      = RST_BREAK_A;
    bp[1]      = RST_BREAK_B;
    bp[2]      = RST_BREAK_C;
    bp[3]      = RST_BREAK_D;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_shape();
    test_left_shoulder();
    test_right_shoulder();
    test_triangle();
    test_unordered_breaks();
    test_unused_index();
    test_random_traffic();

    // all results in, then watch a while for stray strobes
    drain_results();
    repeat (LATENCY + 8) @(posedge clk);

    $display("Sent %0d samples: directed corners of all four shapes plus %0d random settings,",
             items_sent, phases_run);
    $display("including rail, coincident and unordered breakpoints; %0d results checked.",
             results_seen);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/fmu_pkg.sv
hw/rtl/fmu_front.sv
hw/rtl/fmu_cell.sv
hw/rtl/fuzzy_membership_unit.sv
sim/tb.sv
